@@ hdl/crt_pkg.sv @@
// ----------------------------------------------------------------------------
// crt_pkg: shared constants and types for the congruence combiner
// Widths, datapath command codes and the datapath status bundle.
// ----------------------------------------------------------------------------
package crt_pkg;

    // Operand widths.
    localparam int MOD_W = 32;
    localparam int ACC_W = 64;
    localparam int OUT_W = 63;
    localparam int S_W   = MOD_W + 2;
    localparam int ITER_W = 7;

    // Divider iteration counts: full accumulator width or one modulus width.
    localparam logic [ITER_W-1:0] ITER_FULL = ITER_W'(ACC_W);
    localparam logic [ITER_W-1:0] ITER_HALF = ITER_W'(MOD_W);

    // Largest combined modulus that the signed accumulator can hold.
    localparam logic [ACC_W+MOD_W-1:0] MOD_LIMIT =
        {{(MOD_W+1){1'b0}}, {(ACC_W-1){1'b1}}};

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOSOL = 2'd1;
    localparam logic [1:0] ST_OVF   = 2'd2;

    // Datapath commands.
    typedef logic [4:0] t_cmd;
    localparam t_cmd CMD_NONE     = 5'd0;
    localparam t_cmd CMD_LOAD     = 5'd1;
    localparam t_cmd CMD_DIV_BM   = 5'd2;
    localparam t_cmd CMD_DIV_RM   = 5'd3;
    localparam t_cmd CMD_DIV_AM   = 5'd4;
    localparam t_cmd CMD_DIV_EU   = 5'd5;
    localparam t_cmd CMD_DIV_DQ   = 5'd6;
    localparam t_cmd CMD_DIV_N    = 5'd7;
    localparam t_cmd CMD_DIV_PM   = 5'd8;
    localparam t_cmd CMD_DIV_T    = 5'd9;
    localparam t_cmd CMD_CAP_BM   = 5'd10;
    localparam t_cmd CMD_CAP_RM   = 5'd11;
    localparam t_cmd CMD_CAP_AM   = 5'd12;
    localparam t_cmd CMD_CAP_EU   = 5'd13;
    localparam t_cmd CMD_CAP_DQ   = 5'd14;
    localparam t_cmd CMD_CAP_N    = 5'd15;
    localparam t_cmd CMD_CAP_PM   = 5'd16;
    localparam t_cmd CMD_CAP_T    = 5'd17;
    localparam t_cmd CMD_EU_MUL   = 5'd18;
    localparam t_cmd CMD_EU_UPD   = 5'd19;
    localparam t_cmd CMD_T_MUL    = 5'd20;
    localparam t_cmd CMD_W1_LO    = 5'd21;
    localparam t_cmd CMD_W1_HI    = 5'd22;
    localparam t_cmd CMD_W1_SUM   = 5'd23;
    localparam t_cmd CMD_W2_LO    = 5'd24;
    localparam t_cmd CMD_W2_HI    = 5'd25;
    localparam t_cmd CMD_W2_SUM   = 5'd26;
    localparam t_cmd CMD_FAIL_NS  = 5'd27;
    localparam t_cmd CMD_FAIL_OVF = 5'd28;
    localparam t_cmd CMD_COMMIT   = 5'd29;
    localparam t_cmd CMD_OUT      = 5'd30;

    // Status from datapath to controller.
    typedef struct packed {
        logic       div_done;
        logic [1:0] fail;
        logic       mod_zero;
        logic       r1_zero;
        logic       rem_nz;
        logic       ovf;
    } t_dp_status;

endpackage

@@ hdl/crt_in_if.sv @@
// ----------------------------------------------------------------------------
// crt_in_if: congruence request channel
// Valid/ready channel carrying one congruence per request.
// ----------------------------------------------------------------------------
interface crt_in_if;
    logic        valid;
    logic        ready;
    logic        start_new;
    logic [31:0] residue;
    logic [31:0] modulus;

    modport source (output valid, start_new, residue, modulus, input ready);
    modport sink (input valid, start_new, residue, modulus, output ready);
endinterface

@@ hdl/crt_out_if.sv @@
// ----------------------------------------------------------------------------
// crt_out_if: combined congruence result channel
// Valid/ready channel carrying one combined result per request.
// ----------------------------------------------------------------------------
interface crt_out_if;
    logic        valid;
    logic        ready;
    logic [62:0] combined_residue;
    logic [62:0] combined_modulus;
    logic [1:0]  status;

    modport source (output valid, combined_residue, combined_modulus, status,
                    input ready);
    modport sink (input valid, combined_residue, combined_modulus, status,
                  output ready);
endinterface

@@ hdl/crt_div.sv @@
// ----------------------------------------------------------------------------
// crt_div: iterative restoring divider
// Unsigned wide dividend by a modulus-width divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module crt_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [crt_pkg::ACC_W-1:0]        i_dividend,
    input  logic [crt_pkg::MOD_W-1:0]        i_divisor,
    input  logic [crt_pkg::ITER_W-1:0]       i_iters,
    output logic                             o_done,
    output logic [crt_pkg::ACC_W-1:0]        o_quotient,
    output logic [crt_pkg::MOD_W-1:0]        o_remainder
);

    localparam int ITER_W = crt_pkg::ITER_W;

    logic                        r_busy;
    logic                        r_done;
    logic [crt_pkg::ITER_W-1:0]  r_cnt;
    logic [crt_pkg::ACC_W-1:0]   r_dvd;
    logic [crt_pkg::MOD_W-1:0]   r_rem;
    logic [crt_pkg::MOD_W-1:0]   r_dsr;
    logic [crt_pkg::MOD_W:0]     rem_s;
    logic                        ge;
    logic [crt_pkg::MOD_W:0]     rem_sub;

    // One trial subtraction per cycle.
    always_comb begin
        rem_s   = {r_rem, r_dvd[crt_pkg::ACC_W-1]};
        ge      = rem_s >= {1'b0, r_dsr};
        rem_sub = rem_s - {1'b0, r_dsr};
    end

    // Control of the iteration count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_iters;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ITER_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift registers for partial remainder and quotient.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[crt_pkg::ACC_W-2:0], ge};
            r_rem <= ge ? rem_sub[crt_pkg::MOD_W-1:0] : rem_s[crt_pkg::MOD_W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_dvd;
    assign o_remainder = r_rem;

endmodule

@@ hdl/crt_dpath.sv @@
// ----------------------------------------------------------------------------
// crt_dpath: congruence combiner datapath
// Accumulator, extended Euclid registers, shared divider and multipliers.
// ----------------------------------------------------------------------------
module crt_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  crt_pkg::t_cmd                 i_cmd,
    input  logic                          i_start_new,
    input  logic [31:0]                   i_residue,
    input  logic [31:0]                   i_modulus,
    output crt_pkg::t_dp_status           o_status,
    output logic [crt_pkg::OUT_W-1:0]     o_res,
    output logic [crt_pkg::OUT_W-1:0]     o_mod,
    output logic [1:0]                    o_stat
);

    localparam int MW = crt_pkg::MOD_W;
    localparam int AW = crt_pkg::ACC_W;
    localparam int SW = crt_pkg::S_W;

    logic [MW-1:0]        r_b;
    logic [MW-1:0]        r_m;
    logic [AW-1:0]        r_acc_res;
    logic [AW-1:0]        r_acc_mod;
    logic [1:0]           r_fail;
    logic [MW-1:0]        r_bm, r_diff, r_r0, r_r1, r_q, r_t, r_dq, r_n, r_pm, r_tmp;
    logic signed [SW-1:0] r_s0, r_s1, r_qs;
    logic                 r_rem_nz;
    logic [AW-1:0]        r_prod, r_pp_lo, r_pp_hi, r_wres;
    logic [AW+MW-1:0]     r_wmod;
    logic [crt_pkg::OUT_W-1:0] r_o_res, r_o_mod;
    logic [1:0]           r_o_stat;

    logic                 div_start;
    logic [AW-1:0]        div_dvd;
    logic [MW-1:0]        div_dsr;
    logic [crt_pkg::ITER_W-1:0] div_iters;
    logic                 div_done;
    logic [AW-1:0]        div_quo;
    logic [MW-1:0]        div_rem;

    logic [MW-1:0]        b_abs;
    logic signed [SW-1:0] p_neg_val;
    logic [MW-1:0]        p_abs;
    logic [MW-1:0]        w_op;
    logic signed [2*SW-1:0] eu_full;
    logic [AW+MW-1:0]     w_sum;

    // Magnitudes of the signed operands that feed the divider.
    always_comb begin
        b_abs     = r_b[MW-1] ? (~r_b + 1'b1) : r_b;
        p_neg_val = -r_s0;
        p_abs     = r_s0[SW-1] ? p_neg_val[MW-1:0] : r_s0[MW-1:0];
    end

    // Divider operand selection.
    always_comb begin
        div_start = 1'b1;
        div_dvd   = {b_abs, {(AW-MW){1'b0}}};
        div_dsr   = r_m;
        div_iters = crt_pkg::ITER_HALF;
        case (i_cmd)
            crt_pkg::CMD_DIV_BM: begin
                div_dvd = {b_abs, {(AW-MW){1'b0}}};
            end
            crt_pkg::CMD_DIV_RM: begin
                div_dvd   = r_acc_res;
                div_iters = crt_pkg::ITER_FULL;
            end
            crt_pkg::CMD_DIV_AM: begin
                div_dvd   = r_acc_mod;
                div_iters = crt_pkg::ITER_FULL;
            end
            crt_pkg::CMD_DIV_EU: begin
                div_dvd = {r_r0, {(AW-MW){1'b0}}};
                div_dsr = r_r1;
            end
            crt_pkg::CMD_DIV_DQ: begin
                div_dvd = {r_diff, {(AW-MW){1'b0}}};
                div_dsr = r_r0;
            end
            crt_pkg::CMD_DIV_N: begin
                div_dvd = {r_m, {(AW-MW){1'b0}}};
                div_dsr = r_r0;
            end
            crt_pkg::CMD_DIV_PM: begin
                div_dvd = {p_abs, {(AW-MW){1'b0}}};
                div_dsr = r_n;
            end
            crt_pkg::CMD_DIV_T: begin
                div_dvd   = r_prod;
                div_dsr   = r_n;
                div_iters = crt_pkg::ITER_FULL;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    crt_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dvd),
        .i_divisor   (div_dsr),
        .i_iters     (div_iters),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // Multiplier operands and partial product sum.
    always_comb begin
        w_op = (i_cmd == crt_pkg::CMD_W1_LO || i_cmd == crt_pkg::CMD_W1_HI) ? r_tmp : r_n;
        eu_full = $signed({2'b00, r_q}) * r_s1;
        w_sum = {{MW{1'b0}}, r_pp_lo} + {r_pp_hi, {MW{1'b0}}};
    end

    // Accumulated system and failure code.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_res <= '0;
            r_acc_mod <= AW'(1);
            r_fail    <= crt_pkg::ST_OK;
        end else begin
            case (i_cmd)
                crt_pkg::CMD_LOAD: begin
                    if (i_start_new) begin
                        r_acc_res <= '0;
                        r_acc_mod <= AW'(1);
                        r_fail    <= crt_pkg::ST_OK;
                    end
                end
                crt_pkg::CMD_FAIL_NS:  r_fail <= crt_pkg::ST_NOSOL;
                crt_pkg::CMD_FAIL_OVF: r_fail <= crt_pkg::ST_OVF;
                crt_pkg::CMD_COMMIT: begin
                    r_acc_res <= r_acc_res + r_wres;
                    r_acc_mod <= r_wmod[AW-1:0];
                end
                default: ;
            endcase
        end
    end

    // Working registers of the merge.
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            crt_pkg::CMD_LOAD: begin
                r_b <= i_residue[MW-1:0];
                r_m <= i_modulus[MW-1:0];
            end
            crt_pkg::CMD_CAP_BM: begin
                r_bm <= (r_b[MW-1] && div_rem != '0) ? r_m - div_rem : div_rem;
            end
            crt_pkg::CMD_CAP_RM: begin
                r_diff <= (r_bm >= div_rem) ? r_bm - div_rem : r_bm + r_m - div_rem;
            end
            crt_pkg::CMD_CAP_AM: begin
                r_r0 <= div_rem;
                r_r1 <= r_m;
                r_s0 <= SW'(1);
                r_s1 <= '0;
            end
            crt_pkg::CMD_CAP_EU: begin
                r_q <= div_quo[MW-1:0];
                r_t <= div_rem;
            end
            crt_pkg::CMD_EU_MUL: begin
                r_qs <= eu_full[SW-1:0];
            end
            crt_pkg::CMD_EU_UPD: begin
                r_r0 <= r_r1;
                r_r1 <= r_t;
                r_s0 <= r_s1;
                r_s1 <= r_s0 - r_qs;
            end
            crt_pkg::CMD_CAP_DQ: begin
                r_dq     <= div_quo[MW-1:0];
                r_rem_nz <= div_rem != '0;
            end
            crt_pkg::CMD_CAP_N: begin
                r_n <= div_quo[MW-1:0];
            end
            crt_pkg::CMD_CAP_PM: begin
                r_pm <= (r_s0[SW-1] && div_rem != '0) ? r_n - div_rem : div_rem;
            end
            crt_pkg::CMD_T_MUL: begin
                r_prod <= r_dq * r_pm;
            end
            crt_pkg::CMD_CAP_T: begin
                r_tmp <= div_rem;
            end
            crt_pkg::CMD_W1_LO, crt_pkg::CMD_W2_LO: begin
                r_pp_lo <= r_acc_mod[MW-1:0] * w_op;
            end
            crt_pkg::CMD_W1_HI, crt_pkg::CMD_W2_HI: begin
                r_pp_hi <= r_acc_mod[AW-1:MW] * w_op;
            end
            crt_pkg::CMD_W1_SUM: begin
                r_wres <= w_sum[AW-1:0];
            end
            crt_pkg::CMD_W2_SUM: begin
                r_wmod <= w_sum;
            end
            crt_pkg::CMD_OUT: begin
                if (r_fail != crt_pkg::ST_OK) begin
                    r_o_res <= '0;
                    r_o_mod <= '0;
                end else begin
                    r_o_res <= r_acc_res[crt_pkg::OUT_W-1:0];
                    r_o_mod <= r_acc_mod[crt_pkg::OUT_W-1:0];
                end
                r_o_stat <= r_fail;
            end
            default: ;
        endcase
    end

    // Status toward the controller.
    always_comb begin
        o_status.div_done = div_done;
        o_status.fail     = r_fail;
        o_status.mod_zero = r_m == '0;
        o_status.r1_zero  = r_r1 == '0;
        o_status.rem_nz   = r_rem_nz;
        o_status.ovf      = r_wmod > crt_pkg::MOD_LIMIT;
    end

    assign o_res  = r_o_res;
    assign o_mod  = r_o_mod;
    assign o_stat = r_o_stat;

endmodule

@@ hdl/crt_ctrl.sv @@
// ----------------------------------------------------------------------------
// crt_ctrl: congruence combiner controller
// Sequences the merge steps and runs both channel handshakes.
// ----------------------------------------------------------------------------
module crt_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  crt_pkg::t_dp_status  i_status,
    output crt_pkg::t_cmd        o_cmd
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CHK    = 5'd1;
    localparam logic [4:0] S_BM_GO  = 5'd2;
    localparam logic [4:0] S_BM_W   = 5'd3;
    localparam logic [4:0] S_RM_GO  = 5'd4;
    localparam logic [4:0] S_RM_W   = 5'd5;
    localparam logic [4:0] S_AM_GO  = 5'd6;
    localparam logic [4:0] S_AM_W   = 5'd7;
    localparam logic [4:0] S_EU_TST = 5'd8;
    localparam logic [4:0] S_EU_W   = 5'd9;
    localparam logic [4:0] S_EU_MUL = 5'd10;
    localparam logic [4:0] S_EU_UPD = 5'd11;
    localparam logic [4:0] S_DQ_GO  = 5'd12;
    localparam logic [4:0] S_DQ_W   = 5'd13;
    localparam logic [4:0] S_DQ_CHK = 5'd14;
    localparam logic [4:0] S_N_W    = 5'd15;
    localparam logic [4:0] S_PM_GO  = 5'd16;
    localparam logic [4:0] S_PM_W   = 5'd17;
    localparam logic [4:0] S_T_MUL  = 5'd18;
    localparam logic [4:0] S_T_GO   = 5'd19;
    localparam logic [4:0] S_T_W    = 5'd20;
    localparam logic [4:0] S_W1_LO  = 5'd21;
    localparam logic [4:0] S_W1_HI  = 5'd22;
    localparam logic [4:0] S_W1_SUM = 5'd23;
    localparam logic [4:0] S_W2_LO  = 5'd24;
    localparam logic [4:0] S_W2_HI  = 5'd25;
    localparam logic [4:0] S_W2_SUM = 5'd26;
    localparam logic [4:0] S_OVF    = 5'd27;
    localparam logic [4:0] S_OUT    = 5'd28;

    logic [4:0]    r_state, n_state;
    logic          r_out_valid;
    crt_pkg::t_cmd cmd;

    assign o_in_ready = r_state == S_IDLE;

    // Next state and command.
    always_comb begin
        n_state = r_state;
        cmd     = crt_pkg::CMD_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd     = crt_pkg::CMD_LOAD;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (i_status.fail != crt_pkg::ST_OK || i_status.mod_zero) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_BM_GO;
                end
            end
            S_BM_GO: begin
                cmd     = crt_pkg::CMD_DIV_BM;
                n_state = S_BM_W;
            end
            S_BM_W: begin
                if (i_status.div_done) begin
                    cmd     = crt_pkg::CMD_CAP_BM;
                    n_state = S_RM_GO;
                end
            end
            S_RM_GO: begin
                cmd     = crt_pkg::CMD_DIV_RM;
                n_state = S_RM_W;
            end
            S_RM_W: begin
                if (i_status.div_done) begin
                    cmd     = crt_pkg::CMD_CAP_RM;
                    n_state = S_AM_GO;
                end
            end
            S_AM_GO: begin
                cmd     = crt_pkg::CMD_DIV_AM;
                n_state = S_AM_W;
            end
            S_AM_W: begin
                if (i_status.div_done) begin
                    cmd     = crt_pkg::CMD_CAP_AM;
                    n_state = S_EU_TST;
                end
            end
            // One Euclid quotient step per pass through this loop.
            S_EU_TST: begin
                if (i_status.r1_zero) begin
                    n_state = S_DQ_GO;
                end else begin
                    cmd     = crt_pkg::CMD_DIV_EU;
                    n_state = S_EU_W;
                end
            end
            S_EU_W: begin
                if (i_status.div_done) begin
                    cmd     = crt_pkg::CMD_CAP_EU;
                    n_state = S_EU_MUL;
                end
            end
            S_EU_MUL: begin
                cmd     = crt_pkg::CMD_EU_MUL;
                n_state = S_EU_UPD;
            end
            S_EU_UPD: begin
                cmd     = crt_pkg::CMD_EU_UPD;
                n_state = S_EU_TST;
            end
            S_DQ_GO: begin
                cmd     = crt_pkg::CMD_DIV_DQ;
                n_state = S_DQ_W;
            end
            S_DQ_W: begin
                if (i_status.div_done) begin
                    cmd     = crt_pkg::CMD_CAP_DQ;
                    n_state = S_DQ_CHK;
                end
            end
            S_DQ_CHK: begin
                if (i_status.rem_nz) begin
                    cmd     = crt_pkg::CMD_FAIL_NS;
                    n_state = S_OUT;
                end else begin
                    cmd     = crt_pkg::CMD_DIV_N;
                    n_state = S_N_W;
                end
            end
            S_N_W: begin
                if (i_status.div_done) begin
                    cmd     = crt_pkg::CMD_CAP_N;
                    n_state = S_PM_GO;
                end
            end
            S_PM_GO: begin
                cmd     = crt_pkg::CMD_DIV_PM;
                n_state = S_PM_W;
            end
            S_PM_W: begin
                if (i_status.div_done) begin
                    cmd     = crt_pkg::CMD_CAP_PM;
                    n_state = S_T_MUL;
                end
            end
            S_T_MUL: begin
                cmd     = crt_pkg::CMD_T_MUL;
                n_state = S_T_GO;
            end
            S_T_GO: begin
                cmd     = crt_pkg::CMD_DIV_T;
                n_state = S_T_W;
            end
            S_T_W: begin
                if (i_status.div_done) begin
                    cmd     = crt_pkg::CMD_CAP_T;
                    n_state = S_W1_LO;
                end
            end
            S_W1_LO: begin
                cmd     = crt_pkg::CMD_W1_LO;
                n_state = S_W1_HI;
            end
            S_W1_HI: begin
                cmd     = crt_pkg::CMD_W1_HI;
                n_state = S_W1_SUM;
            end
            S_W1_SUM: begin
                cmd     = crt_pkg::CMD_W1_SUM;
                n_state = S_W2_LO;
            end
            S_W2_LO: begin
                cmd     = crt_pkg::CMD_W2_LO;
                n_state = S_W2_HI;
            end
            S_W2_HI: begin
                cmd     = crt_pkg::CMD_W2_HI;
                n_state = S_W2_SUM;
            end
            S_W2_SUM: begin
                cmd     = crt_pkg::CMD_W2_SUM;
                n_state = S_OVF;
            end
            S_OVF: begin
                cmd     = i_status.ovf ? crt_pkg::CMD_FAIL_OVF : crt_pkg::CMD_COMMIT;
                n_state = S_OUT;
            end
            // Load the output register once the previous result is gone.
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd     = crt_pkg::CMD_OUT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and output valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd == crt_pkg::CMD_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

@@ hdl/crt_congruence_combiner.sv @@
// ----------------------------------------------------------------------------
// crt_congruence_combiner: generalized Chinese remainder combiner
// Merges congruences with arbitrary moduli into one running congruence.
// ----------------------------------------------------------------------------
// The shared bit-serial divider, on accumulator-wide or modulus-wide operands,
// runs once per Euclid quotient step plus seven times per merge.
// One request at a time: the next is taken once the result is in the output
// register. Sticky failures and zero moduli go from the check to the output state.
// Reset: synchronous active low; clears the system to residue 0, modulus 1.
module crt_congruence_combiner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    crt_in_if.sink      i_in,
    crt_out_if.source   o_out
);

    crt_pkg::t_cmd       cmd;
    crt_pkg::t_dp_status status;

    crt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    crt_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_start_new (i_in.start_new),
        .i_residue   (i_in.residue),
        .i_modulus   (i_in.modulus),
        .o_status    (status),
        .o_res       (o_out.combined_residue),
        .o_mod       (o_out.combined_modulus),
        .o_stat      (o_out.status)
    );

endmodule

@@ hdl/crt_checker.sv @@
// ----------------------------------------------------------------------------
// crt_checker: port-level assertions for the congruence combiner
// Watches both channels and the result fields over time.
// ----------------------------------------------------------------------------
module crt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [62:0] i_res,
    input logic [62:0] i_mod,
    input logic [1:0]  i_stat
);

    // A held result keeps its fields.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_res) &&
        $stable(i_mod) && $stable(i_stat))
        else $error("result changed while stalled");

    // A good result lies below a nonzero modulus.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_stat == crt_pkg::ST_OK |-> i_mod != '0 && i_res < i_mod)
        else $error("combined residue out of range");

    // A failure reports zero fields.
    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_stat != crt_pkg::ST_OK |-> i_res == '0 && i_mod == '0)
        else $error("failure result has nonzero fields");

    // One request at a time: acceptance closes the input.
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second request taken during merge");

endmodule

bind crt_congruence_combiner crt_checker u_crt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_res       (o_out.combined_residue),
    .i_mod       (o_out.combined_modulus),
    .i_stat      (o_out.status)
);
